// ----- design/gn_pkg.sv -----
// shared types and constants of the gradient noise block
package gn_pkg;

  localparam int unsigned CELL_W  = 6;
  localparam int unsigned GRAD_W  = 16;
  localparam int unsigned POS_W   = 22;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned MODE_W  = 2;

  localparam int NOISE_MAX = 32767;
  localparam int NOISE_MIN = -32768;

  // ease curve coefficients
  localparam int unsigned SS_A = 3;
  localparam int unsigned SS_B = 2;
  localparam int unsigned SM_A = 6;
  localparam int unsigned SM_B = 15;
  localparam int unsigned SM_C = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR   = 2'd0,
    MODE_SMOOTH   = 2'd1,
    MODE_SMOOTHER = 2'd2,
    MODE_OFF      = 2'd3
  } interp_mode_e;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_e;

  typedef struct packed {
    logic              eval;
    logic              wen;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_z;
    logic [GRAD_W-1:0] grad_x;
    logic [GRAD_W-1:0] grad_z;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_z;
  } mid_item_t;

endpackage

// ----- design/gn_ram.sv -----
// generic single-port-write ram with registered read
module gn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/gn_queue.sv -----
// small flop-based fifo
module gn_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ----- design/gn_front.sv -----
// front end: accepts words, classifies them and range-checks writes
module gn_front #(
  parameter int unsigned GRID_X_SIZE = 64,
  parameter int unsigned GRID_Z_SIZE = 64
) (
  input  logic                                push_i,
  output logic                                full_o,
  input  logic                                action_i,
  input  logic        [gn_pkg::CELL_W-1:0]    cell_x_i,
  input  logic        [gn_pkg::CELL_W-1:0]    cell_z_i,
  input  logic signed [gn_pkg::GRAD_W-1:0]    grad_x_i,
  input  logic signed [gn_pkg::GRAD_W-1:0]    grad_z_i,
  input  logic        [gn_pkg::POS_W-1:0]     pos_x_i,
  input  logic        [gn_pkg::POS_W-1:0]     pos_z_i,
  output logic                                q_push_o,
  output gn_pkg::mid_item_t                   q_item_o,
  input  logic                                q_full_i
);
  import gn_pkg::*;

  logic is_eval;

  assign is_eval  = (action_e'(action_i) == ACT_EVAL);
  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    q_item_o.eval   = is_eval;
    q_item_o.wen    = !is_eval && (32'(cell_x_i) < GRID_X_SIZE)
                      && (32'(cell_z_i) < GRID_Z_SIZE);
    q_item_o.cell_x = cell_x_i;
    q_item_o.cell_z = cell_z_i;
    q_item_o.grad_x = grad_x_i;
    q_item_o.grad_z = grad_z_i;
    q_item_o.pos_x  = pos_x_i;
    q_item_o.pos_z  = pos_z_i;
  end

endmodule

// ----- design/gn_back.sv -----
// back end: cell reduction, gradient lookup, dot products, ease and blend pipeline
module gn_back #(
  parameter int unsigned GRID_X_SIZE = 64,
  parameter int unsigned GRID_Z_SIZE = 64,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gn_pkg::interp_mode_e              mode_i,
  input  logic                              q_empty_i,
  input  gn_pkg::mid_item_t                 q_item_i,
  output logic                              q_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic signed [gn_pkg::NOISE_W-1:0] noise_value_o
);
  import gn_pkg::*;

  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned IW     = (F < POS_W) ? POS_W - F : 1;
  localparam int unsigned NR     = (IW + 1) / 2;
  localparam int unsigned XW     = $clog2(GRID_X_SIZE);
  localparam int unsigned ZW     = $clog2(GRID_Z_SIZE);
  localparam int unsigned DEPTH  = GRID_X_SIZE * GRID_Z_SIZE;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned ODEPTH = 2 ** $clog2(NR + 11);
  localparam int unsigned KW     = $clog2(ODEPTH + 1);
  localparam int unsigned SW     = F + 2;
  localparam int unsigned DXW    = F + 2;
  localparam int unsigned PW     = DXW + GRAD_W;
  localparam int unsigned DW     = GRAD_W + 3;
  localparam int unsigned LW     = DW + 2;
  localparam int unsigned BW     = DW + SW + 2;
  localparam int unsigned CB     = LW + SW + 2;
  localparam int unsigned HALFV  = 1 << (F - 1);

  typedef struct packed {
    logic                eval;
    logic                wen;
    logic [CELL_W-1:0]   cx;
    logic [CELL_W-1:0]   cz;
    logic [2*GRAD_W-1:0] wdata;
    logic [IW-1:0]       ix;
    logic [IW-1:0]       iz;
    logic [F-1:0]        fx;
    logic [F-1:0]        fz;
  } red_t;

  typedef struct packed {
    logic                eval;
    logic                wen;
    logic [AW-1:0]       waddr;
    logic [2*GRAD_W-1:0] wdata;
    logic [3:0][AW-1:0]  addr;
    logic [F-1:0]        fx;
    logic [F-1:0]        fz;
    logic [F-1:0]        w2x;
    logic [F-1:0]        w2z;
  } stage_a_t;

  typedef struct packed {
    logic [F-1:0]   fx;
    logic [F-1:0]   fz;
    logic [SW-1:0]  ssx;
    logic [SW-1:0]  ssz;
    logic [F-1:0]   w3x;
    logic [F-1:0]   w3z;
    logic [F+3:0]   px;
    logic [F+3:0]   pz;
  } stage_r_t;

  // one restoring step of the modulo reduction
  function automatic logic [IW-1:0] red_step(input logic [IW-1:0] v, input int unsigned m,
                                             input int unsigned t);
    logic [31:0] sub;
    logic [31:0] vw;
    sub = '0;
    vw  = 32'(v);
    if (t < IW) begin
      sub = 32'(m) << (IW - 1 - t);
    end
    if (t < IW && vw >= sub) begin
      vw = vw - sub;
    end
    return vw[IW-1:0];
  endfunction

  function automatic logic [F-1:0] ease_w2(input logic [F-1:0] f);
    logic [2*F-1:0] pr;
    pr = f * f;
    return pr[2*F-1:F];
  endfunction

  function automatic logic [SW-1:0] ease_ss(input logic [F-1:0] w2, input logic [F-1:0] f);
    logic [F+1:0]   t;
    logic [2*F+1:0] pr;
    t  = ((F+2)'(SS_A) << F) - (F+2)'(f) * (F+2)'(SS_B);
    pr = w2 * t;
    return pr[2*F+1:F];
  endfunction

  function automatic logic [F-1:0] ease_w3(input logic [F-1:0] w2, input logic [F-1:0] f);
    logic [2*F-1:0] pr;
    pr = w2 * f;
    return pr[2*F-1:F];
  endfunction

  function automatic logic [F+3:0] ease_p(input logic [F-1:0] w2, input logic [F-1:0] f);
    logic [F+3:0] pos;
    logic [F+3:0] neg;
    pos = (F+4)'(w2) * (F+4)'(SM_A) + ((F+4)'(SM_C) << F);
    neg = (F+4)'(f) * (F+4)'(SM_B);
    return (pos >= neg) ? pos - neg : '0;
  endfunction

  function automatic logic [SW-1:0] ease_pick(input interp_mode_e m, input logic [F-1:0] f,
                                              input logic [SW-1:0] ss, input logic [F-1:0] w3,
                                              input logic [F+3:0] p);
    logic [2*F+3:0] pr;
    logic [SW-1:0]  s;
    pr = w3 * p;
    case (m)
      MODE_LINEAR:   s = SW'(f);
      MODE_SMOOTH:   s = ss;
      MODE_SMOOTHER: s = SW'(pr[2*F+3:F]);
      default:       s = '0;
    endcase
    return s;
  endfunction

  // intake with output credit
  logic          take, oq_push, oq_pop, oq_full, oq_empty;
  logic [KW-1:0] cnt_q;

  assign take    = !q_empty_i && (!q_item_i.eval || cnt_q < KW'(ODEPTH));
  assign q_pop_o = take;
  assign oq_pop  = pop_i && !oq_empty;
  assign empty_o = oq_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (take && q_item_i.eval && !oq_pop) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (oq_pop && !(take && q_item_i.eval)) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // cell index reduction
  red_t        red_q [NR+1];
  red_t        red_d [NR+1];
  logic [NR:0] rv_q;

  always_comb begin
    red_d[0].eval  = q_item_i.eval;
    red_d[0].wen   = q_item_i.wen;
    red_d[0].cx    = q_item_i.cell_x;
    red_d[0].cz    = q_item_i.cell_z;
    red_d[0].wdata = {q_item_i.grad_z, q_item_i.grad_x};
    red_d[0].ix    = IW'(q_item_i.pos_x >> F);
    red_d[0].iz    = IW'(q_item_i.pos_z >> F);
    red_d[0].fx    = F'(q_item_i.pos_x);
    red_d[0].fz    = F'(q_item_i.pos_z);
    for (int j = 1; j <= NR; j++) begin
      red_d[j]    = red_q[j-1];
      red_d[j].ix = red_step(red_step(red_q[j-1].ix, GRID_X_SIZE, 2*j-2), GRID_X_SIZE, 2*j-1);
      red_d[j].iz = red_step(red_step(red_q[j-1].iz, GRID_Z_SIZE, 2*j-2), GRID_Z_SIZE, 2*j-1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= '0;
    end else begin
      rv_q <= {rv_q[NR-1:0], take};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= NR; j++) begin
      red_q[j] <= red_d[j];
    end
  end

  // corner addresses
  red_t          rr;
  logic [XW-1:0] x0, x1;
  logic [ZW-1:0] z0, z1;
  stage_a_t      a_d, a_q;
  logic          va_q;

  assign rr = red_q[NR];

  always_comb begin
    x0 = XW'(rr.ix);
    z0 = ZW'(rr.iz);
    x1 = (32'(x0) == GRID_X_SIZE - 1) ? '0 : x0 + 1'b1;
    z1 = (32'(z0) == GRID_Z_SIZE - 1) ? '0 : z0 + 1'b1;
    a_d.eval    = rr.eval;
    a_d.wen     = rr.wen;
    a_d.waddr   = AW'(32'(rr.cx) * GRID_Z_SIZE + 32'(rr.cz));
    a_d.wdata   = rr.wdata;
    a_d.addr[0] = AW'(32'(x0) * GRID_Z_SIZE + 32'(z0));
    a_d.addr[1] = AW'(32'(x1) * GRID_Z_SIZE + 32'(z0));
    a_d.addr[2] = AW'(32'(x0) * GRID_Z_SIZE + 32'(z1));
    a_d.addr[3] = AW'(32'(x1) * GRID_Z_SIZE + 32'(z1));
    a_d.fx      = rr.fx;
    a_d.fz      = rr.fz;
    a_d.w2x     = ease_w2(rr.fx);
    a_d.w2z     = ease_w2(rr.fz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= rv_q[NR];
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  // gradient banks, one copy per corner
  logic                ram_we;
  logic [2*GRAD_W-1:0] grad_q [4];

  assign ram_we = va_q && !a_q.eval && a_q.wen;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    gn_ram #(
      .WIDTH(2*GRAD_W),
      .DEPTH(DEPTH)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .waddr_i(a_q.waddr),
      .wdata_i(a_q.wdata),
      .raddr_i(a_q.addr[b]),
      .rdata_o(grad_q[b])
    );
  end

  // ease middle step
  stage_r_t r_q;
  logic     vr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= va_q && a_q.eval;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q.fx  <= a_q.fx;
    r_q.fz  <= a_q.fz;
    r_q.ssx <= ease_ss(a_q.w2x, a_q.fx);
    r_q.ssz <= ease_ss(a_q.w2z, a_q.fz);
    r_q.w3x <= ease_w3(a_q.w2x, a_q.fx);
    r_q.w3z <= ease_w3(a_q.w2z, a_q.fz);
    r_q.px  <= ease_p(a_q.w2x, a_q.fx);
    r_q.pz  <= ease_p(a_q.w2z, a_q.fz);
  end

  // dot product terms
  logic signed [DXW-1:0] dxa, dxb, dza, dzb;
  logic signed [PW-1:0]  pm_d [8];
  logic signed [PW-1:0]  pm_q [8];
  logic        [SW-1:0]  sxp_q, szp_q;
  logic                  vp_q;

  always_comb begin
    dxa = $signed({2'b00, r_q.fx});
    dza = $signed({2'b00, r_q.fz});
    dxb = dxa - $signed(DXW'(1) << F);
    dzb = dza - $signed(DXW'(1) << F);
    pm_d[0] = dxa * $signed(grad_q[0][GRAD_W-1:0]);
    pm_d[1] = dza * $signed(grad_q[0][2*GRAD_W-1:GRAD_W]);
    pm_d[2] = dxb * $signed(grad_q[1][GRAD_W-1:0]);
    pm_d[3] = dza * $signed(grad_q[1][2*GRAD_W-1:GRAD_W]);
    pm_d[4] = dxa * $signed(grad_q[2][GRAD_W-1:0]);
    pm_d[5] = dzb * $signed(grad_q[2][2*GRAD_W-1:GRAD_W]);
    pm_d[6] = dxb * $signed(grad_q[3][GRAD_W-1:0]);
    pm_d[7] = dzb * $signed(grad_q[3][2*GRAD_W-1:GRAD_W]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      pm_q[k] <= pm_d[k];
    end
    sxp_q <= ease_pick(mode_i, r_q.fx, r_q.ssx, r_q.w3x, r_q.px);
    szp_q <= ease_pick(mode_i, r_q.fz, r_q.ssz, r_q.w3z, r_q.pz);
  end

  // corner values rounded to q1.14
  logic signed [PW:0]   dsum [4];
  logic signed [DW-1:0] d_q [4];
  logic        [SW-1:0] sxs_q, szs_q;
  logic                 vs_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dsum[c] = ((PW+1)'(pm_q[2*c]) + (PW+1)'(pm_q[2*c+1]) + $signed((PW+1)'(HALFV))) >>> F;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else begin
      vs_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      d_q[c] <= DW'(dsum[c]);
    end
    sxs_q <= sxp_q;
    szs_q <= szp_q;
  end

  // blend along x
  logic signed [BW-1:0] bp0_q, bp1_q;
  logic signed [DW-1:0] d00_q, d01_q;
  logic        [SW-1:0] sz1_q;
  logic                 vb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q <= 1'b0;
    end else begin
      vb1_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bp0_q <= ((DW+1)'(d_q[1]) - (DW+1)'(d_q[0])) * $signed({1'b0, sxs_q});
    bp1_q <= ((DW+1)'(d_q[3]) - (DW+1)'(d_q[2])) * $signed({1'b0, sxs_q});
    d00_q <= d_q[0];
    d01_q <= d_q[2];
    sz1_q <= szs_q;
  end

  logic signed [BW-1:0] t0, t1;
  logic signed [LW-1:0] i0_q, i1_q;
  logic        [SW-1:0] sz2_q;
  logic                 vb2_q;

  assign t0 = (bp0_q + $signed(BW'(HALFV))) >>> F;
  assign t1 = (bp1_q + $signed(BW'(HALFV))) >>> F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb2_q <= 1'b0;
    end else begin
      vb2_q <= vb1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i0_q  <= LW'(d00_q) + LW'(t0);
    i1_q  <= LW'(d01_q) + LW'(t1);
    sz2_q <= sz1_q;
  end

  // blend along z
  logic signed [CB-1:0] bp2_q;
  logic signed [LW-1:0] i0b_q;
  logic                 vb3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb3_q <= 1'b0;
    end else begin
      vb3_q <= vb2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bp2_q <= ((LW+1)'(i1_q) - (LW+1)'(i0_q)) * $signed({1'b0, sz2_q});
    i0b_q <= i0_q;
  end

  logic signed [CB-1:0]      t2;
  logic signed [LW+1:0]      rs;
  logic signed [NOISE_W-1:0] res;

  always_comb begin
    t2 = (bp2_q + $signed(CB'(HALFV))) >>> F;
    rs = (LW+2)'(i0b_q) + (LW+2)'(t2);
    if (mode_i == MODE_OFF) begin
      res = '0;
    end else if (rs > (LW+2)'(NOISE_MAX)) begin
      res = NOISE_W'(NOISE_MAX);
    end else if (rs < (LW+2)'(NOISE_MIN)) begin
      res = NOISE_W'(NOISE_MIN);
    end else begin
      res = NOISE_W'(rs);
    end
  end

  assign oq_push = vb3_q;

  gn_queue #(
    .WIDTH(NOISE_W),
    .DEPTH(ODEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (oq_push),
    .data_i (res),
    .full_o (oq_full),
    .pop_i  (pop_i),
    .data_o (noise_value_o),
    .empty_o(oq_empty)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= KW'(ODEPTH))
    else $error("credit count above output queue depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) oq_push |-> !oq_full)
    else $error("result pushed into full output queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !oq_empty |-> cnt_q != '0)
    else $error("waiting result without credit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> (32'(a_q.addr[3]) < DEPTH) && (32'(a_q.addr[0]) < DEPTH))
    else $error("corner address outside grid");

  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> 32'(a_q.waddr) < DEPTH)
    else $error("gradient write outside grid");

endmodule

// ----- design/gradient_noise_2d.sv -----
// top level of the 2d gradient noise block
//
// Input channel: a word is taken when push is high and full is low. action_i
// low stores grad_x_i/grad_z_i at cell (cell_x_i, cell_z_i); cells outside the
// grid are dropped. action_i high evaluates noise at (pos_x_i, pos_z_i).
// Result channel: while empty is low, noise_value_o holds the oldest result;
// it is removed when pop is high. Only evaluate words give a result.
// cfg_we_i writes cfg_wdata_i into the ease mode register; write it only
// while no word is in flight.
// Throughput: one word per cycle while evaluate words find a free output
// queue slot. From accept to result visible, a word passes the mid queue,
// the cell reduction steps, the registered gradient ram read and the blend
// multipliers. A stalled result side fills the output queue; the pipeline
// admits evaluate words only while a slot is reserved, so full rises once
// the small input queue is also full. Reset clears both queues, the pipeline
// and the mode (linear); gradients must be written before they are read.
module gradient_noise_2d #(
  parameter int unsigned GRID_X_SIZE = 64,
  parameter int unsigned GRID_Z_SIZE = 64,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              action_i,
  input  logic        [gn_pkg::CELL_W-1:0]  cell_x_i,
  input  logic        [gn_pkg::CELL_W-1:0]  cell_z_i,
  input  logic signed [gn_pkg::GRAD_W-1:0]  grad_x_i,
  input  logic signed [gn_pkg::GRAD_W-1:0]  grad_z_i,
  input  logic        [gn_pkg::POS_W-1:0]   pos_x_i,
  input  logic        [gn_pkg::POS_W-1:0]   pos_z_i,
  input  logic                              cfg_we_i,
  input  logic        [gn_pkg::MODE_W-1:0]  cfg_wdata_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [gn_pkg::NOISE_W-1:0] noise_value_o
);
  import gn_pkg::*;

  interp_mode_e mode_q;
  logic         mq_push, mq_full, mq_pop, mq_empty;
  mid_item_t    mq_in, mq_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINEAR;
    end else if (cfg_we_i) begin
      mode_q <= interp_mode_e'(cfg_wdata_i);
    end
  end

  gn_front #(
    .GRID_X_SIZE(GRID_X_SIZE),
    .GRID_Z_SIZE(GRID_Z_SIZE)
  ) u_front (
    .push_i  (push),
    .full_o  (full),
    .action_i(action_i),
    .cell_x_i(cell_x_i),
    .cell_z_i(cell_z_i),
    .grad_x_i(grad_x_i),
    .grad_z_i(grad_z_i),
    .pos_x_i (pos_x_i),
    .pos_z_i (pos_z_i),
    .q_push_o(mq_push),
    .q_item_o(mq_in),
    .q_full_i(mq_full)
  );

  gn_queue #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(4)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mq_push),
    .data_i (mq_in),
    .full_o (mq_full),
    .pop_i  (mq_pop),
    .data_o (mq_out),
    .empty_o(mq_empty)
  );

  gn_back #(
    .GRID_X_SIZE(GRID_X_SIZE),
    .GRID_Z_SIZE(GRID_Z_SIZE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .q_empty_i    (mq_empty),
    .q_item_i     (mq_out),
    .q_pop_o      (mq_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .noise_value_o(noise_value_o)
  );

endmodule
